>>> sv/sgi_pkg.sv
`default_nettype none
package sgi_pkg;

  localparam int GAIN_W       = 32;
  localparam int NUM_GAINS    = 3;
  localparam int GAIN_IDX_W   = 2;
  localparam int DIV_BITS     = 2;
  localparam int DIV_CYCLES   = GAIN_W / DIV_BITS;
  localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);
  localparam int COUNT_W      = 5;
  localparam int INDEX_W      = 4;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [GAIN_IDX_W-1:0] GAIN_LAST = GAIN_IDX_W'(NUM_GAINS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_SEG,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_ACC,
    S_EMIT
  } sgi_state_t;

  // gain[0] = P, gain[1] = I, gain[2] = D
  typedef struct packed {
    logic signed [GAIN_W-1:0]            bp;
    logic [NUM_GAINS-1:0][GAIN_W-1:0]    gain;
  } sgi_entry_t;

endpackage
`default_nettype wire

>>> sv/sgi_if.sv
`default_nettype none
interface sgi_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  entry_index;
  logic signed [31:0] breakpoint_speed;
  logic signed [31:0] load_gain_p;
  logic signed [31:0] load_gain_i;
  logic signed [31:0] load_gain_d;
  logic signed [31:0] speed;

  modport source (output valid, action, entry_index, breakpoint_speed,
                  load_gain_p, load_gain_i, load_gain_d, speed,
                  input ready);
  modport sink (input valid, action, entry_index, breakpoint_speed,
                load_gain_p, load_gain_i, load_gain_d, speed,
                output ready);
endinterface

interface sgi_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic        gains_valid;

  modport source (output valid, gain_p, gain_i, gain_d, gains_valid, input ready);
  modport sink (input valid, gain_p, gain_i, gain_d, gains_valid, output ready);
endinterface
`default_nettype wire

>>> sv/speed_scheduled_gain_interpolator.sv
`default_nettype none
// Load beat: written at the accept edge; the next beat can be accepted in the next cycle.
// Query beat: an empty table goes straight to the result; at or below the first breakpoint
// or at or above the last, that entry's gains result; else the scan reads one entry a cycle,
// then for a matching segment, per gain a 32x32 multiply and a 2-bit-per-cycle divide.
// The next beat can be accepted in the cycle after the result loads; a held result stalls input.
// Reset (rst, synchronous): table reads zero, breakpoint_count = 1, sequencer idle.
module speed_scheduled_gain_interpolator #(
  parameter int MAX_BREAKPOINTS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_en,
  input  wire logic [sgi_pkg::COUNT_W-1:0] cfg_write_data,
  sgi_in_if.sink                     req,
  sgi_out_if.source                  rsp
);
  import sgi_pkg::*;

  localparam int AW = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
  localparam int NW = $clog2(MAX_BREAKPOINTS + 1);

  sgi_state_t state, state_next;

  logic [COUNT_W-1:0] breakpoint_count;

  sgi_entry_t mem [MAX_BREAKPOINTS];
  logic [MAX_BREAKPOINTS-1:0] ent_valid;
  sgi_entry_t rd_data;
  logic rd_vld;
  logic [AW-1:0] addr_rd;
  sgi_entry_t ent;

  logic signed [GAIN_W-1:0] v;
  logic [NW-1:0] n;
  logic [NW-1:0] n_clamped;
  logic [AW-1:0] k;
  sgi_entry_t seg_lo, seg_hi;
  logic [GAIN_W-1:0] dv, w;
  logic [GAIN_IDX_W-1:0] gi;
  logic [GAIN_W-1:0] mag;
  logic neg;
  logic [GAIN_W-1:0] rem, quo;
  logic [GAIN_W-1:0] rem_step, quo_step;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [NUM_GAINS-1:0][GAIN_W-1:0] res_gain;
  logic res_valid;

  logic out_valid;
  logic [NUM_GAINS-1:0][GAIN_W-1:0] out_gain;
  logic out_gvalid;

  logic accept;
  logic load_ok;
  logic match;
  logic scan_end;
  logic emit_load;
  logic signed [GAIN_W:0] dg;
  logic [GAIN_W:0] dg_abs;
  logic [2*GAIN_W-1:0] prod;
  logic [GAIN_W-1:0] lo_g;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign load_ok   = (32'(req.entry_index) < MAX_BREAKPOINTS);
  assign n_clamped = (32'(breakpoint_count) > MAX_BREAKPOINTS) ?
                     NW'(MAX_BREAKPOINTS) : NW'(breakpoint_count);

  assign ent      = rd_vld ? rd_data : '0;
  assign match    = (v >= seg_lo.bp) && (v < ent.bp);
  assign scan_end = (NW'(k) + NW'(1)) == (n - NW'(1));
  assign emit_load = !out_valid || rsp.ready;

  // magnitude of the gain step for the current gain
  assign lo_g   = seg_lo.gain[gi];
  assign dg     = $signed({seg_hi.gain[gi][GAIN_W-1], seg_hi.gain[gi]}) -
                  $signed({lo_g[GAIN_W-1], lo_g});
  assign dg_abs = dg[GAIN_W] ? 33'(-dg) : 33'(dg);
  assign prod   = dv * mag;

  always_comb begin
    logic [GAIN_W-1:0] r;
    logic [GAIN_W-1:0] q;
    logic [GAIN_W:0]   t;
    r = rem;
    q = quo;
    for (int s = 0; s < DIV_BITS; s++) begin
      t = {r, q[GAIN_W-1]};
      q = {q[GAIN_W-2:0], 1'b0};
      if (t >= {1'b0, w}) begin
        r = GAIN_W'(t - {1'b0, w});
        q[0] = 1'b1;
      end else begin
        r = t[GAIN_W-1:0];
      end
    end
    rem_step = r;
    quo_step = q;
  end

  always_comb begin
    case (state)
      S_FIRST: addr_rd = AW'(n - NW'(1));
      S_LAST:  addr_rd = AW'(1);
      S_SCAN:  addr_rd = AW'(32'(k) + 2);
      default: addr_rd = '0;
    endcase
  end

  // table memory, one registered read port
  always_ff @(posedge clk) begin
    if (accept && req.action == ACT_LOAD && load_ok) begin
      mem[AW'(req.entry_index)] <= '{bp: req.breakpoint_speed,
                                     gain: {req.load_gain_d, req.load_gain_i,
                                            req.load_gain_p}};
    end
    rd_data <= mem[addr_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld <= ent_valid[addr_rd];
      if (accept && req.action == ACT_LOAD && load_ok) begin
        ent_valid[AW'(req.entry_index)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      breakpoint_count <= COUNT_W'(1);
    end else if (cfg_write_en) begin
      breakpoint_count <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && req.action == ACT_QUERY) begin
          state_next = (n_clamped == '0) ? S_EMIT : S_FIRST;
        end
      end
      S_FIRST: begin
        if (v <= ent.bp || n == NW'(1)) state_next = S_EMIT;
        else state_next = S_LAST;
      end
      S_LAST: begin
        if (v >= ent.bp) state_next = S_EMIT;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        if (match) state_next = S_SEG;
        else if (scan_end) state_next = S_EMIT;
      end
      S_SEG:   state_next = S_SETUP;
      S_SETUP: state_next = S_MUL;
      S_MUL:   state_next = S_DIV;
      S_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) state_next = S_ACC;
      end
      S_ACC: begin
        if (gi == GAIN_LAST) state_next = S_EMIT;
        else state_next = S_SETUP;
      end
      S_EMIT: begin
        if (emit_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept && req.action == ACT_QUERY) begin
          v         <= req.speed;
          n         <= n_clamped;
          res_gain  <= '0;
          res_valid <= (n_clamped != '0);
        end
      end
      S_FIRST: begin
        seg_lo <= ent;
        if (v <= ent.bp || n == NW'(1)) res_gain <= ent.gain;
      end
      S_LAST: begin
        k <= '0;
        if (v >= ent.bp) res_gain <= ent.gain;
      end
      S_SCAN: begin
        if (match) begin
          seg_hi <= ent;
        end else begin
          seg_lo <= ent;
          k      <= AW'(32'(k) + 1);
        end
      end
      S_SEG: begin
        dv <= GAIN_W'(v - seg_lo.bp);
        w  <= GAIN_W'(seg_hi.bp - seg_lo.bp);
        gi <= '0;
      end
      S_SETUP: begin
        mag <= dg_abs[GAIN_W-1:0];
        neg <= dg[GAIN_W];
      end
      S_MUL: begin
        // high half stays below w since dv < w
        rem     <= prod[2*GAIN_W-1:GAIN_W];
        quo     <= prod[GAIN_W-1:0];
        div_cnt <= '0;
      end
      S_DIV: begin
        rem     <= rem_step;
        quo     <= quo_step;
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      S_ACC: begin
        res_gain[gi] <= neg ? (lo_g - quo) : (lo_g + quo);
        gi           <= gi + GAIN_IDX_W'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_load) begin
      out_gain   <= res_gain;
      out_gvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && emit_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.gain_p      = out_gain[0];
  assign rsp.gain_i      = out_gain[1];
  assign rsp.gain_d      = out_gain[2];
  assign rsp.gains_valid = out_gvalid;

endmodule
`default_nettype wire
